// ----- design/mfb_pkg.sv -----
// Shared types and constants for the monochrome frame buffer raster engine.
// Holds display geometry, request codes and the structs passed between modules.
// No dependencies.
package mfb_pkg;

	localparam int DISPLAY_WIDTH  = 160;
	localparam int DISPLAY_HEIGHT = 80;
	localparam int ROW_BYTES      = (DISPLAY_WIDTH + 7) / 8;
	localparam int STORE_BYTES    = ROW_BYTES * DISPLAY_HEIGHT;
	localparam int ADDR_W         = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
	localparam int CB_W           = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
	localparam int ROW_W          = (DISPLAY_HEIGHT > 1) ? $clog2(DISPLAY_HEIGHT) : 1;
	// Internal column/row width: holds x_start + 7 and the display limits.
	localparam int COL_W          = 11;

	localparam logic [COL_W-1:0] WIDTH_C    = COL_W'(DISPLAY_WIDTH);
	localparam logic [COL_W-1:0] HEIGHT_C   = COL_W'(DISPLAY_HEIGHT);
	localparam logic [COL_W-1:0] ROW_BITS_C = COL_W'(ROW_BYTES * 8);

	// Request codes
	localparam logic [2:0] REQ_CLEAR    = 3'd0;
	localparam logic [2:0] REQ_POINT    = 3'd1;
	localparam logic [2:0] REQ_FILL     = 3'd2;
	localparam logic [2:0] REQ_BITMAP   = 3'd3;
	localparam logic [2:0] REQ_POINT_RD = 3'd4;
	localparam logic [2:0] REQ_BYTE_RD  = 3'd5;

	localparam logic [7:0] MSB_BIT = 8'h80;

	typedef struct packed {
		logic [2:0] req_type;
		logic [9:0] x_start;
		logic [9:0] y_start;
		logic [9:0] x_end;
		logic [9:0] y_end;
		logic [7:0] pixel_color;
		logic [7:0] pixel_byte;
		logic [3:0] bit_count;
	} req_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       clipped;
	} result_t;

	// Byte walk over a block of the store, with the column window to modify
	typedef struct packed {
		logic             do_walk;
		logic             report;
		logic             clip;
		logic             is_write;
		logic             is_read;
		logic             is_point_rd;
		logic [ROW_W-1:0] row0;
		logic [ROW_W-1:0] row1;
		logic [CB_W-1:0]  col0;
		logic [CB_W-1:0]  col1;
		logic [COL_W-1:0] lo;
		logic [COL_W-1:0] hi;
		logic [15:0]      data16;
		logic [2:0]       shift;
		logic [7:0]       rmask;
	} walk_t;

	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [7:0]        wr_data;
	} mem_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_WALK,
		ST_DRAIN,
		ST_DONE
	} eng_state_t;

	// Walk that zeroes every byte of the store, used after reset
	function automatic walk_t init_walk();
		walk_t w;
		w             = '0;
		w.do_walk     = 1'b1;
		w.is_write    = 1'b1;
		w.row1        = ROW_W'(DISPLAY_HEIGHT - 1);
		w.col1        = CB_W'(ROW_BYTES - 1);
		w.hi          = ROW_BITS_C - COL_W'(1);
		return w;
	endfunction

endpackage

// ----- design/mfb_store.sv -----
// Frame store: one byte per entry, one write and one registered read port.
// Depends on mfb_pkg for the store depth and address width.
module mfb_store import mfb_pkg::*; (
	input  logic       clk,
	input  mem_req_t   mem_req,
	output logic [7:0] rd_data
);

	logic [7:0] mem [STORE_BYTES];

	// Write port
	always_ff @(posedge clk) begin
		if (mem_req.wr_en) begin
			mem[mem_req.wr_addr] <= mem_req.wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (mem_req.rd_en) begin
			rd_data <= mem[mem_req.rd_addr];
		end
	end

endmodule

// ----- design/mfb_req_decode.sv -----
// Request decoder: turns one request into a clipped byte walk and clip flag.
// Depends on mfb_pkg for geometry, request codes and walk_t.
module mfb_req_decode import mfb_pkg::*; (
	input  req_t       req,
	input  logic [7:0] back_color,
	output walk_t      walk
);

	logic [3:0]       n_eff;
	logic [7:0]       nmask;
	logic [COL_W-1:0] xs, xe, ys, ye, xlast;
	logic [COL_W-1:0] fill_hi, fill_row1, byte_hi;
	logic             x_on, y_on, nonempty, fg;

	// Clamp the bit count and build the common bounds
	always_comb begin
		n_eff     = (req.bit_count > 4'd8) ? 4'd8 : req.bit_count;
		nmask     = ~(8'hFF >> n_eff);
		xs        = {1'b0, req.x_start};
		xe        = {1'b0, req.x_end};
		ys        = {1'b0, req.y_start};
		ye        = {1'b0, req.y_end};
		xlast     = xs + COL_W'(n_eff) - COL_W'(1);
		x_on      = xs < WIDTH_C;
		y_on      = ys < HEIGHT_C;
		nonempty  = (xs <= xe) && (ys <= ye);
		fg        = req.pixel_color != back_color;
		fill_hi   = (xe < WIDTH_C) ? xe : WIDTH_C - COL_W'(1);
		fill_row1 = (ye < HEIGHT_C) ? ye : HEIGHT_C - COL_W'(1);
		byte_hi   = (xlast < WIDTH_C) ? xlast : WIDTH_C - COL_W'(1);
	end

	// Per-request walk setup
	always_comb begin
		walk        = '0;
		walk.report = 1'b1;
		walk.row0   = ROW_W'(ys);
		walk.row1   = ROW_W'(ys);
		walk.col0   = CB_W'(xs >> 3);
		walk.col1   = CB_W'(xs >> 3);
		walk.lo     = xs;
		walk.hi     = xs;
		walk.shift  = req.x_start[2:0];
		walk.data16 = {16{fg}};
		case (req.req_type)
			REQ_CLEAR: begin
				walk        = init_walk();
				walk.report = 1'b1;
			end
			REQ_POINT: begin
				walk.do_walk  = x_on && y_on;
				walk.clip     = !(x_on && y_on);
				walk.is_write = 1'b1;
			end
			REQ_FILL: begin
				walk.do_walk  = nonempty && x_on && y_on;
				walk.clip     = nonempty && ((xe >= WIDTH_C) || (ye >= HEIGHT_C));
				walk.is_write = 1'b1;
				walk.row1     = ROW_W'(fill_row1);
				walk.col1     = CB_W'(fill_hi >> 3);
				walk.hi       = fill_hi;
			end
			REQ_BITMAP: begin
				walk.do_walk  = (n_eff != 4'd0) && x_on && y_on;
				walk.clip     = (n_eff != 4'd0) && (!y_on || (xlast >= WIDTH_C));
				walk.is_write = 1'b1;
				walk.col1     = CB_W'(byte_hi >> 3);
				walk.hi       = byte_hi;
				walk.data16   = {req.pixel_byte & nmask, 8'h00} >> req.x_start[2:0];
			end
			REQ_POINT_RD: begin
				walk.do_walk     = x_on && y_on;
				walk.clip        = !(x_on && y_on);
				walk.is_read     = 1'b1;
				walk.is_point_rd = 1'b1;
				walk.rmask       = MSB_BIT;
			end
			REQ_BYTE_RD: begin
				walk.do_walk = (n_eff != 4'd0) && x_on && y_on;
				walk.clip    = (n_eff != 4'd0) && (!y_on || (xlast >= WIDTH_C));
				walk.is_read = 1'b1;
				walk.col1    = CB_W'(byte_hi >> 3);
				walk.hi      = byte_hi;
				walk.rmask   = nmask;
			end
			default: begin
				walk.do_walk = 1'b0;
			end
		endcase
	end

endmodule

// ----- design/mfb_engine.sv -----
// Raster engine: sequences byte walks over the store with read-modify-write.
// Depends on mfb_pkg and mfb_req_decode; drives the mfb_store port struct.
module mfb_engine import mfb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  req_t       req,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	output logic       res_valid,
	input  logic       res_ready,
	output result_t    res,
	output mem_req_t   mem_req,
	input  logic [7:0] rd_data
);

	localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(ROW_BYTES);

	eng_state_t              state_q, state_d;
	walk_t                   walk_dec, wc_q;
	logic [7:0]              back_color_q;
	logic [ROW_W-1:0]        row_q;
	logic [CB_W-1:0]         col_q;
	logic [ADDR_W-1:0]       base_q;
	logic [ADDR_W+ROW_W-1:0] row_base;
	logic [15:0]             gather_q, gather_sh;
	logic                    valid_s1, kidx_s1;
	logic [ADDR_W-1:0]       addr_s1;
	logic [CB_W-1:0]         col_s1;
	logic [7:0]              mask_s1, data_s1;
	logic [COL_W-1:0]        colj;
	logic                    last_col, last_row, accept;

	mfb_req_decode u_decode (
		.req        (req),
		.back_color (back_color_q),
		.walk       (walk_dec)
	);

	assign last_col = col_q == wc_q.col1;
	assign last_row = row_q == wc_q.row1;
	assign row_base = wc_q.row0 * ROW_STEP;
	assign accept   = in_valid && in_ready;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SETUP;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake outputs
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = walk_dec.do_walk ? ST_SETUP : ST_DONE;
				end
			end
			ST_SETUP: state_d = ST_WALK;
			ST_WALK: begin
				if (last_col && last_row) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_DONE;
			ST_DONE: begin
				res_valid = wc_q.report;
				if (!wc_q.report || res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold the request's walk and the background color
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q         <= init_walk();
			back_color_q <= 8'h00;
		end else begin
			if (accept) begin
				wc_q <= walk_dec;
				if (req.req_type == REQ_CLEAR) begin
					back_color_q <= req.pixel_color;
				end
			end
			if (cfg_we) begin
				back_color_q <= cfg_wdata;
			end
		end
	end

	// Advance the byte walk: columns within a row, then rows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			base_q <= '0;
		end else if (state_q == ST_SETUP) begin
			row_q  <= wc_q.row0;
			col_q  <= wc_q.col0;
			base_q <= row_base[ADDR_W-1:0];
		end else if (state_q == ST_WALK) begin
			if (last_col) begin
				col_q <= wc_q.col0;
				if (!last_row) begin
					row_q  <= row_q + ROW_W'(1);
					base_q <= base_q + ROW_STEP;
				end
			end else begin
				col_q <= col_q + CB_W'(1);
			end
		end
	end

	// Read stage: issue the read, carry the address into the modify stage
	assign mem_req.rd_en   = state_q == ST_WALK;
	assign mem_req.rd_addr = base_q + ADDR_W'(col_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= state_q == ST_WALK;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= mem_req.rd_addr;
		col_s1  <= col_q;
		kidx_s1 <= col_q[0] ^ wc_q.col0[0];
	end

	// Modify stage: bits whose column lies in the window take the new data
	always_comb begin
		mask_s1 = '0;
		colj    = '0;
		for (int j = 0; j < 8; j++) begin
			colj          = COL_W'({col_s1, 3'b000}) + COL_W'(j);
			mask_s1[7-j]  = (colj >= wc_q.lo) && (colj <= wc_q.hi);
		end
		data_s1 = kidx_s1 ? wc_q.data16[7:0] : wc_q.data16[15:8];
	end

	assign mem_req.wr_en   = valid_s1 && wc_q.is_write;
	assign mem_req.wr_addr = addr_s1;
	assign mem_req.wr_data = (rd_data & ~mask_s1) | (data_s1 & mask_s1);

	// Gather read bytes into a two-byte window
	always_ff @(posedge clk) begin
		if (accept) begin
			gather_q <= '0;
		end else if (valid_s1 && wc_q.is_read) begin
			if (kidx_s1) begin
				gather_q[7:0] <= rd_data;
			end else begin
				gather_q[15:8] <= rd_data;
			end
		end
	end

	// Align the window to the start column and form the result
	assign gather_sh = gather_q << wc_q.shift;

	always_comb begin
		res.clipped   = wc_q.clip;
		res.read_byte = '0;
		if (wc_q.is_point_rd) begin
			res.read_byte = {7'b0, gather_sh[15]};
		end else if (wc_q.is_read) begin
			res.read_byte = gather_sh[15:8] & wc_q.rmask;
		end
	end

	a_idle_no_s1: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !valid_s1)
		else $error("modify stage busy while engine idle");

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.wr_en |-> mem_req.wr_addr < ADDR_W'(STORE_BYTES))
		else $error("store write beyond last entry");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.rd_en && mem_req.wr_en |-> mem_req.rd_addr != mem_req.wr_addr)
		else $error("read and write hit the same entry in one cycle");

	a_walk_after_setup: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_WALK) |-> $past(state_q) == ST_SETUP)
		else $error("walk entered without setup");

endmodule

// ----- design/mono_framebuffer_raster_engine.sv -----
// Top level of the monochrome frame buffer raster engine.
// Depends on mfb_pkg, mfb_engine and mfb_store; adds the result register.
//
//  channel   | direction | accepted when              | payload
//  ----------+-----------+----------------------------+--------------------------------
//  s_axis    | in        | s_axis_tvalid & tready     | request (tuser kind, tdata args)
//  m_axis    | out       | m_axis_tvalid & tready     | read_byte in tdata, clipped tuser
//  cfg       | in        | cfg_we                     | back_color
//
// A request walks the bytes it touches at one byte per cycle through the
// store's read and write ports, with a setup state before the walk and a
// drain state after it; a rejected request skips setup, walk and drain.
// After reset the engine zeroes the store in one pass over every byte,
// with s_axis_tready low; configuration writes are taken throughout.
// A finished result waits in the output register while the next request runs.
module mono_framebuffer_raster_engine import mfb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// x_start[9:0], y_start[19:10], x_end[29:20], y_end[39:30],
	// pixel_color[47:40], pixel_byte[55:48], bit_count[59:56], zero fill
	input  logic [63:0] s_axis_tdata,
	// req_type[2:0]
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// read_byte[7:0]
	output logic [7:0]  m_axis_tdata,
	// clipped[0]
	output logic [0:0]  m_axis_tuser,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);

	req_t     req;
	result_t  res, out_q;
	mem_req_t mem_req;
	logic     res_valid, res_ready, out_valid_q;
	logic [7:0] rd_data;

	// Unpack the request
	always_comb begin
		req.req_type    = s_axis_tuser;
		req.x_start     = s_axis_tdata[9:0];
		req.y_start     = s_axis_tdata[19:10];
		req.x_end       = s_axis_tdata[29:20];
		req.y_end       = s_axis_tdata[39:30];
		req.pixel_color = s_axis_tdata[47:40];
		req.pixel_byte  = s_axis_tdata[55:48];
		req.bit_count   = s_axis_tdata[59:56];
	end

	mfb_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_req   (mem_req),
		.rd_data   (rd_data)
	);

	mfb_store u_store (
		.clk     (clk),
		.mem_req (mem_req),
		.rd_data (rd_data)
	);

	// Output register: load a result when empty or being drained
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = out_q.read_byte;
	assign m_axis_tuser[0] = out_q.clipped;

endmodule
